FILE: rtl/sobel3_pkg.sv
// ----------------------------------------------------------------------------
// sobel3_pkg
// Types and fixed constants for the 3x3 Sobel gradient filter.
// ----------------------------------------------------------------------------
package sobel3_pkg;

    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int ROW_W      = 12;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

    typedef logic [PIX_W-1:0]         t_pix;
    typedef logic signed [GRAD_W-1:0] t_grad;
    typedef logic [ROW_W-1:0]         t_row;

    // register index = paddr[2]
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

endpackage

FILE: rtl/sobel_3x3_gradient.sv
// ----------------------------------------------------------------------------
// sobel_3x3_gradient
// Streaming 3x3 Sobel filter: two line buffers in one RAM, a 3x3 window and
// registered gradient output for interior pixels only.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  input    | i_in_valid / o_in_stall   | i_pixel
//  output   | o_out_valid / i_out_stall | o_grad_x, o_grad_y, o_frame_last
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
//  One pixel per clock sustained while the output is not stalled. A pixel is
//  accepted into stage 1 while the line RAM is read at its column; when stage 1
//  advances, the gradients are registered and the line RAM is written back.
//  Border pixels produce no result and never wait on the output side.
//  i_out_stall holds stage 1 only when an interior result is waiting.
//  Reset (synchronous, active low) clears counters and valids; the line RAM
//  is not cleared, since every entry is rewritten before a result uses it.
//  A register write restarts the frame.
// ----------------------------------------------------------------------------
module sobel_3x3_gradient #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sobel3_pkg::APB_AW-1:0]          paddr,
    input  logic [sobel3_pkg::APB_DW-1:0]          pwdata,
    output logic [sobel3_pkg::APB_DW-1:0]          prdata,
    output logic                                  pready,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  sobel3_pkg::t_pix                      i_pixel,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output sobel3_pkg::t_grad                     o_grad_x,
    output sobel3_pkg::t_grad                     o_grad_y,
    output logic                                  o_frame_last
);

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WBN = $clog2(MAX_WIDTH + 1);
    localparam int WB  = (WBN > sobel3_pkg::FW_W) ? WBN : sobel3_pkg::FW_W;
    localparam int MW  = 2 * sobel3_pkg::PIX_W;

    // ---------------- configuration ----------------
    logic [sobel3_pkg::FW_W-1:0] r_frame_width;
    logic [sobel3_pkg::FH_W-1:0] r_frame_height;
    logic                        cfg_wr;
    sobel3_pkg::t_reg_idx        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = sobel3_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= sobel3_pkg::FRAME_WIDTH_RST;
            r_frame_height <= sobel3_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                sobel3_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[sobel3_pkg::FW_W-1:0];
                sobel3_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[sobel3_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            sobel3_pkg::REG_FRAME_WIDTH:
                prdata = sobel3_pkg::APB_DW'(r_frame_width);
            sobel3_pkg::REG_FRAME_HEIGHT:
                prdata = sobel3_pkg::APB_DW'(r_frame_height);
            default:
                prdata = '0;
        endcase
    end

    // effective frame size, clamped
    logic [WB-1:0]              w_ext;
    logic [WB-1:0]              w_eff;
    logic [AW-1:0]              w_last;
    logic [sobel3_pkg::FH_W-1:0] h_eff;
    sobel3_pkg::t_row           h_last;

    always_comb begin
        w_ext = WB'(r_frame_width);
        if (w_ext < WB'(sobel3_pkg::MIN_DIM))
            w_eff = WB'(sobel3_pkg::MIN_DIM);
        else if (w_ext > WB'(MAX_WIDTH))
            w_eff = WB'(MAX_WIDTH);
        else
            w_eff = w_ext;
        w_last = AW'(w_eff - WB'(1));

        if (r_frame_height < sobel3_pkg::FH_W'(sobel3_pkg::MIN_DIM))
            h_eff = sobel3_pkg::FH_W'(sobel3_pkg::MIN_DIM);
        else if (r_frame_height > sobel3_pkg::FH_W'(sobel3_pkg::MAX_HEIGHT))
            h_eff = sobel3_pkg::FH_W'(sobel3_pkg::MAX_HEIGHT);
        else
            h_eff = r_frame_height;
        h_last = sobel3_pkg::ROW_W'(h_eff - sobel3_pkg::FH_W'(1));
    end

    // ---------------- handshake ----------------
    logic r_s1_vld;
    logic r_s1_int;
    logic r_out_vld;
    logic s1_adv;
    logic in_acc;

    assign s1_adv     = r_s1_vld && (!r_s1_int || !r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // ---------------- position counters ----------------
    logic [AW-1:0]    r_col, n_col;
    sobel3_pkg::t_row r_row, n_row;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_acc) begin
            if (r_col == w_last) begin
                n_col = '0;
                n_row = (r_row == h_last) ? '0 : r_row + sobel3_pkg::ROW_W'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- line RAM: {top, mid} per column ----------------
    logic [MW-1:0]   r_line_mem [MAX_WIDTH];
    logic [MW-1:0]   r_rd_data;
    sobel3_pkg::t_pix top_px;
    sobel3_pkg::t_pix mid_px;

    assign top_px = r_rd_data[MW-1:sobel3_pkg::PIX_W];
    assign mid_px = r_rd_data[sobel3_pkg::PIX_W-1:0];

    // ---------------- stage 1 ----------------
    sobel3_pkg::t_pix r_s1_pix;
    logic [AW-1:0]    r_s1_col;
    logic             r_s1_last;

    always_ff @(posedge i_clk) begin
        if (in_acc)
            r_rd_data <= r_line_mem[r_col];
        if (s1_adv)
            r_line_mem[r_s1_col] <= {mid_px, r_s1_pix};
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix  <= i_pixel;
            r_s1_col  <= r_col;
            r_s1_last <= (r_row == h_last) && (r_col == w_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s1_int <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
            r_s1_int <= (r_row >= sobel3_pkg::ROW_W'(2)) && (r_col >= AW'(2));
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
            r_s1_int <= 1'b0;
        end
    end

    // ---------------- window and gradients ----------------
    sobel3_pkg::t_pix r_lt, r_lm, r_lb, r_ct, r_cm, r_cb;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_lt <= r_ct;
            r_lm <= r_cm;
            r_lb <= r_cb;
            r_ct <= top_px;
            r_cm <= mid_px;
            r_cb <= r_s1_pix;
        end
    end

    logic [9:0]        sum_l, sum_r, sum_t, sum_b;
    sobel3_pkg::t_grad gx, gy;

    always_comb begin
        sum_l = 10'(r_lt) + {1'b0, r_lm, 1'b0} + 10'(r_lb);
        sum_r = 10'(top_px) + {1'b0, mid_px, 1'b0} + 10'(r_s1_pix);
        sum_t = 10'(r_lt) + {1'b0, r_ct, 1'b0} + 10'(top_px);
        sum_b = 10'(r_lb) + {1'b0, r_cb, 1'b0} + 10'(r_s1_pix);
        gx    = sobel3_pkg::t_grad'({1'b0, sum_l}) - sobel3_pkg::t_grad'({1'b0, sum_r});
        gy    = sobel3_pkg::t_grad'({1'b0, sum_t}) - sobel3_pkg::t_grad'({1'b0, sum_b});
    end

    // ---------------- output register ----------------
    sobel3_pkg::t_grad r_out_gx, r_out_gy;
    logic              r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_vld <= 1'b0;
        else if (s1_adv && r_s1_int)
            r_out_vld <= 1'b1;
        else if (!i_out_stall)
            r_out_vld <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_int) begin
            r_out_gx   <= gx;
            r_out_gy   <= gy;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_grad_x     = r_out_gx;
    assign o_grad_y     = r_out_gy;
    assign o_frame_last = r_out_last;

endmodule

FILE: bench/sobel_3x3_gradient_test.sv
// ----------------------------------------------------------------------------
// sobel_3x3_gradient_test
// Self-checking bench for the streaming 3x3 Sobel gradient filter. Pixels go
// in through the valid/stall channel; a behavioral line-buffer predictor
// computes the expected interior gradients, and every output transaction is
// compared in order. Covers reset defaults, gradient extremes, dimension
// clamping and random frame sizes with random idling on both channels.
// ----------------------------------------------------------------------------
module sobel_3x3_gradient_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W          = 2048;
    localparam int RANDOM_PIXELS  = 750;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct packed {
        sobel3_pkg::t_grad gx;
        sobel3_pkg::t_grad gy;
        logic              last;
    } t_gradient;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [sobel3_pkg::APB_AW-1:0]   paddr;
    logic [sobel3_pkg::APB_DW-1:0]   pwdata;
    logic [sobel3_pkg::APB_DW-1:0]   prdata;
    logic                            pready;
    logic                            i_in_valid;
    logic                            o_in_stall;
    sobel3_pkg::t_pix                i_pixel;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    sobel3_pkg::t_grad               o_grad_x;
    sobel3_pkg::t_grad               o_grad_y;
    logic                            o_frame_last;

    // predictor state
    logic [sobel3_pkg::FW_W-1:0]     cfg_width;
    logic [sobel3_pkg::FH_W-1:0]     cfg_height;
    sobel3_pkg::t_pix                row_m1 [MAX_W];
    sobel3_pkg::t_pix                row_m2 [MAX_W];
    sobel3_pkg::t_pix                col_old [3];
    sobel3_pkg::t_pix                col_new [3];
    int unsigned                     col_pos;
    int unsigned                     row_pos;
    t_gradient                       grad_expected [$];

    int unsigned         pixels_sent;
    int unsigned         grads_checked;
    int unsigned         reg_writes;
    int unsigned         fail_count;
    int unsigned         cycle_count;
    int unsigned         out_stall_pct;
    int unsigned         in_gap_pct;
    int unsigned         stall_left;

    sobel_3x3_gradient #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_grad_x    (o_grad_x),
        .o_grad_y    (o_grad_y),
        .o_frame_last(o_frame_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned eff_dim(input int unsigned v, input int unsigned hi);
        if (v < sobel3_pkg::MIN_DIM) return sobel3_pkg::MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    // window/line-buffer model: one call per accepted pixel
    function automatic void predict_gradient(input sobel3_pkg::t_pix value);
        int unsigned w;
        int unsigned h;
        int          top;
        int          mid;
        int          bot;
        t_gradient   g;
        w = eff_dim(cfg_width, MAX_W);
        h = eff_dim(cfg_height, sobel3_pkg::MAX_HEIGHT);
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        top = row_m2[col_pos];
        mid = row_m1[col_pos];
        bot = value;
        if (row_pos >= 2 && col_pos >= 2) begin
            g.gx   = sobel3_pkg::GRAD_W'(
                         (int'(col_old[0]) + 2 * int'(col_old[1]) + int'(col_old[2]))
                         - (top + 2 * mid + bot));
            g.gy   = sobel3_pkg::GRAD_W'(
                         (int'(col_old[0]) + 2 * int'(col_new[0]) + top)
                         - (int'(col_old[2]) + 2 * int'(col_new[2]) + bot));
            g.last = (row_pos == h - 1) && (col_pos == w - 1);
            grad_expected = {grad_expected, g};
        end
        row_m2[col_pos] = sobel3_pkg::t_pix'(mid);
        row_m1[col_pos] = value;
        col_old = col_new;
        col_new = '{sobel3_pkg::t_pix'(top), sobel3_pkg::t_pix'(mid), value};
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    function automatic sobel3_pkg::t_pix random_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return sobel3_pkg::t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int unsigned pick_dim(input int unsigned typ_hi, input int unsigned wide_hi);
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 2) return $urandom_range(0, sobel3_pkg::MIN_DIM - 1);
        if (roll < 17) return $urandom_range(sobel3_pkg::MIN_DIM, typ_hi);
        return $urandom_range(typ_hi + 1, wide_hi);
    endfunction

    // output side: random stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n || out_stall_pct == 0) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < out_stall_pct) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_gradient g;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            grads_checked++;
            if (grad_expected.size() == 0) begin
                $error("unexpected gradient transaction: grad_x %0d grad_y %0d",
                       $signed(o_grad_x), $signed(o_grad_y));
                fail_count++;
            end else begin
                g = grad_expected.pop_front();
                if (o_grad_x !== g.gx) begin
                    $error("grad_x: expected %0d, got %0d", $signed(g.gx), $signed(o_grad_x));
                    fail_count++;
                end
                if (o_grad_y !== g.gy) begin
                    $error("grad_y: expected %0d, got %0d", $signed(g.gy), $signed(o_grad_y));
                    fail_count++;
                end
                if (o_frame_last !== g.last) begin
                    $error("frame_last: expected %0b, got %0b", g.last, o_frame_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d gradients outstanding",
                 cycle_count, grad_expected.size());
        $display("sobel_3x3_gradient regression: fail");
        $finish;
    end

    // All tasks below start and return just after a falling edge.

    task automatic send_pixel(input sobel3_pkg::t_pix value);
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= value;
        do @(posedge i_clk); while (o_in_stall);
        predict_gradient(value);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (grad_expected.size() != 0) @(negedge i_clk);
        // border pixels may still be in the pipe with nothing expected
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_transfer(input logic is_write, input sobel3_pkg::t_reg_idx idx,
                                input logic [sobel3_pkg::APB_DW-1:0] wdata,
                                output logic [sobel3_pkg::APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_reg(input sobel3_pkg::t_reg_idx idx,
                             input logic [sobel3_pkg::APB_DW-1:0] expected);
        logic [sobel3_pkg::APB_DW-1:0] rdata;
        apb_transfer(1'b0, idx, '0, rdata);
        if (rdata !== expected) begin
            $error("%s: expected %0d, got %0d", idx.name(), expected, rdata);
            fail_count++;
        end
    endtask

    // any register write restarts the frame
    task automatic write_reg(input sobel3_pkg::t_reg_idx idx, input int unsigned value);
        logic [sobel3_pkg::APB_DW-1:0] unused;
        logic [sobel3_pkg::APB_DW-1:0] stored;
        apb_transfer(1'b1, idx, sobel3_pkg::APB_DW'(value), unused);
        if (idx == sobel3_pkg::REG_FRAME_WIDTH) begin
            cfg_width = sobel3_pkg::FW_W'(value);
            stored    = sobel3_pkg::APB_DW'(cfg_width);
        end else begin
            cfg_height = sobel3_pkg::FH_W'(value);
            stored     = sobel3_pkg::APB_DW'(cfg_height);
        end
        col_pos = 0;
        row_pos = 0;
        reg_writes++;
        check_reg(idx, stored);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        wait_drained();
        write_reg(sobel3_pkg::REG_FRAME_WIDTH, w);
        write_reg(sobel3_pkg::REG_FRAME_HEIGHT, h);
    endtask

    task automatic test_reset_defaults();
        check_reg(sobel3_pkg::REG_FRAME_WIDTH, sobel3_pkg::APB_DW'(sobel3_pkg::FRAME_WIDTH_RST));
        check_reg(sobel3_pkg::REG_FRAME_HEIGHT,
                  sobel3_pkg::APB_DW'(sobel3_pkg::FRAME_HEIGHT_RST));
        out_stall_pct = 20;
        in_gap_pct    = 20;
        // still in the top row of the default frame: no gradient expected
        repeat (80) send_pixel(random_pixel());
    endtask

    task automatic test_gradient_extremes();
        out_stall_pct = 30;
        in_gap_pct    = 30;
        // columns 255,0,0,255: +1020 then -1020 horizontally
        set_frame(4, 3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++)
                send_pixel((c == 0 || c == 3) ? sobel3_pkg::t_pix'(255)
                                              : sobel3_pkg::t_pix'(0));
        // rows 255,0,0,255: +1020 then -1020 vertically
        set_frame(3, 4);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 3; c++)
                send_pixel((r == 0 || r == 3) ? sobel3_pkg::t_pix'(255)
                                              : sobel3_pkg::t_pix'(0));
    endtask

    task automatic test_dimension_clamping();
        out_stall_pct = 20;
        in_gap_pct    = 20;
        // below minimum on both axes: 3x3, run into the next frame
        set_frame(0, 1);
        repeat (11) send_pixel(random_pixel());
        set_frame(2, 2);
        repeat (9) send_pixel(random_pixel());
        // widest: 4095 clamps to the line buffer size, top row only
        set_frame(4095, 3);
        repeat (30) send_pixel(random_pixel());
        // tallest: 8191 clamps to the row limit, first rows only
        set_frame(3, 8191);
        repeat (30) send_pixel(random_pixel());
        // exact height limit, cut short by the next write
        set_frame(sobel3_pkg::MIN_DIM, sobel3_pkg::MAX_HEIGHT);
        repeat (20) send_pixel(random_pixel());
    endtask

    task automatic test_random_frames();
        int unsigned base;
        int unsigned w;
        int unsigned h;
        int unsigned area;
        int unsigned frames;
        int unsigned pix_count;
        int unsigned remaining;
        base = pixels_sent;
        while (pixels_sent - base < RANDOM_PIXELS) begin
            w = pick_dim(12, 64);
            h = pick_dim(6, 12);
            wait_drained();
            if (pixels_sent - base + 150 > RANDOM_PIXELS) begin
                out_stall_pct = 0;
                in_gap_pct    = 0;
            end else begin
                out_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
                in_gap_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            end
            if ($urandom_range(0, 1) != 0) begin
                write_reg(sobel3_pkg::REG_FRAME_WIDTH, w);
                write_reg(sobel3_pkg::REG_FRAME_HEIGHT, h);
            end else begin
                write_reg(sobel3_pkg::REG_FRAME_HEIGHT, h);
                write_reg(sobel3_pkg::REG_FRAME_WIDTH, w);
            end
            area      = eff_dim(w, MAX_W) * eff_dim(h, sobel3_pkg::MAX_HEIGHT);
            frames    = (area > 200) ? 1 : $urandom_range(1, 3);
            pix_count = frames * area;
            // sometimes leave a frame half done; the next write restarts it
            if ($urandom_range(0, 9) < 3)
                pix_count += $urandom_range(1, area - 1);
            remaining = RANDOM_PIXELS - (pixels_sent - base);
            if (pix_count > remaining)
                pix_count = remaining;
            repeat (pix_count) send_pixel(random_pixel());
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_pixel       <= '0;
        out_stall_pct = 0;
        in_gap_pct    = 0;
        pixels_sent   = 0;
        grads_checked = 0;
        reg_writes    = 0;
        fail_count    = 0;
        cfg_width     = sobel3_pkg::FRAME_WIDTH_RST;
        cfg_height    = sobel3_pkg::FRAME_HEIGHT_RST;
        col_pos       = 0;
        row_pos       = 0;
        col_old       = '{default: '0};
        col_new       = '{default: '0};
        foreach (row_m1[i]) begin
            row_m1[i] = '0;
            row_m2[i] = '0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_gradient_extremes();
        test_dimension_clamping();
        test_random_frames();

        wait_drained();
        repeat (10) @(negedge i_clk);
        $display("sent %0d pixels with %0d register writes: defaults, +-1020 extremes,",
                 pixels_sent, reg_writes);
        $display("size clamping and random frames up to 64x12; %0d gradients checked",
                 grads_checked);
        $display("in %0d cycles, %0d mismatches", cycle_count, fail_count);
        if (fail_count == 0 && grad_expected.size() == 0) begin
            $display("sobel_3x3_gradient regression: pass");
        end else begin
            $display("sobel_3x3_gradient regression: fail");
        end
        $finish;
    end

endmodule
